// ===== rtl/core/pct_pkg.sv =====
// Package for the palette color table: default sizes, result status codes
// and the bit depth function. Depends on nothing.
package pct_pkg;

  localparam int unsigned DefTableEntries = 256;
  localparam int unsigned DefColorLimit   = 128;
  localparam int unsigned DepthSteps      = 8;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StInserted = 2'd1,
    StMissed   = 2'd2,
    StFull     = 2'd3
  } status_e;

  // Counts how many of 1, 2, 4, ..., 128 do not exceed the color count.
  function automatic logic [3:0] depth_of(input logic [31:0] count);
    logic [3:0] d;
    d = '0;
    for (int k = 0; k < DepthSteps; k++) begin
      if (count >= (32'd1 << k)) begin
        d = d + 4'd1;
      end
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/pct_store.sv =====
// Color store of the palette color table: one write port and one read port
// with registered read data. Depends on nothing.
module pct_store #(
  parameter int unsigned Entries = 256,
  parameter int unsigned Width   = 24,
  localparam int unsigned AddrW  = $clog2(Entries)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Entries];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pct_ctrl.sv =====
// Search and insert sequencer of the palette color table. Scans the color
// store in insertion order and appends on a learn miss. Uses pct_pkg.
module pct_ctrl #(
  parameter int unsigned TableEntries = pct_pkg::DefTableEntries,
  parameter int unsigned ColorLimit   = pct_pkg::DefColorLimit,
  localparam int unsigned IdxW        = $clog2(TableEntries),
  localparam int unsigned CntW        = $clog2(TableEntries + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            action_i,
  input  logic [23:0]     pixel_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [7:0]      palette_index_o,
  output logic [1:0]      status_o,
  output logic [8:0]      color_count_o,
  output logic [3:0]      bit_depth_o,
  output logic            over_limit_o,
  output logic [IdxW-1:0] mem_raddr_o,
  input  logic [23:0]     mem_rdata_i,
  output logic            mem_we_o,
  output logic [IdxW-1:0] mem_waddr_o,
  output logic [23:0]     mem_wdata_o
);

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Finish
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [IdxW-1:0] hit_idx_q;
  logic            hit_q;
  logic            act_q;
  logic [23:0]     pix_q;
  logic            done_q;
  logic [7:0]      index_q;
  logic [1:0]      status_q;
  logic [8:0]      ccount_q;
  logic [3:0]      depth_q;
  logic            over_q;

  logic            match;
  logic            last;
  logic            room;
  logic            insert;
  logic [CntW-1:0] count_d;

  assign match   = (mem_rdata_i == pix_q);
  assign last    = ((CntW'(cmp_idx_q) + CntW'(1)) == count_q);
  assign room    = (count_q < CntW'(TableEntries));
  assign insert  = (state_q == Finish) && !hit_q && !act_q && room;
  assign count_d = insert ? count_q + CntW'(1) : count_q;

  always_comb begin
    if (state_q == Scan) begin
      mem_raddr_o = cmp_idx_q + IdxW'(1);
    end else begin
      mem_raddr_o = '0;
    end
  end

  assign mem_we_o    = insert;
  assign mem_waddr_o = count_q[IdxW-1:0];
  assign mem_wdata_o = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      count_q   <= '0;
      cmp_idx_q <= '0;
      hit_idx_q <= '0;
      hit_q     <= 1'b0;
      act_q     <= 1'b0;
      pix_q     <= '0;
      done_q    <= 1'b0;
      index_q   <= '0;
      status_q  <= '0;
      ccount_q  <= '0;
      depth_q   <= '0;
      over_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        Idle: begin
          if (start_i) begin
            act_q     <= action_i;
            pix_q     <= pixel_i;
            cmp_idx_q <= '0;
            hit_q     <= 1'b0;
            state_q   <= (count_q == '0) ? Finish : Scan;
          end
        end
        Scan: begin
          if (match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
            state_q   <= Finish;
          end else if (last) begin
            state_q <= Finish;
          end else begin
            cmp_idx_q <= cmp_idx_q + IdxW'(1);
          end
        end
        Finish: begin
          count_q  <= count_d;
          done_q   <= 1'b1;
          ccount_q <= 9'(count_d);
          depth_q  <= pct_pkg::depth_of(32'(count_d));
          over_q   <= (32'(count_d) > 32'(ColorLimit));
          if (hit_q) begin
            index_q  <= 8'(hit_idx_q);
            status_q <= pct_pkg::StFound;
          end else if (act_q) begin
            index_q  <= '0;
            status_q <= pct_pkg::StMissed;
          end else if (room) begin
            index_q  <= 8'(count_q);
            status_q <= pct_pkg::StInserted;
          end else begin
            index_q  <= '0;
            status_q <= pct_pkg::StFull;
          end
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign busy_o          = (state_q != Idle);
  assign done_o          = done_q;
  assign palette_index_o = index_q;
  assign status_o        = status_q;
  assign color_count_o   = ccount_q;
  assign bit_depth_o     = depth_q;
  assign over_limit_o    = over_q;

endmodule

// ===== rtl/core/palette_color_table.sv =====
// The search reads the color store from index 0 until a hit or the last
// stored color, then finishes (an empty table skips the scan): one read of the
// color store per cycle. A new start is taken in the cycle done_o is high.
// Reset clears the color count at once; the store itself is never cleared.
// Results are shown for one cycle on done_o and cannot be stalled.
module palette_color_table #(
  parameter int unsigned TableEntries = pct_pkg::DefTableEntries,
  parameter int unsigned ColorLimit   = pct_pkg::DefColorLimit
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [23:0] pixel_i,
  output logic        done_o,
  output logic [7:0]  palette_index_o,
  output logic [1:0]  status_o,
  output logic [8:0]  color_count_o,
  output logic [3:0]  bit_depth_o,
  output logic        over_limit_o
);

  localparam int unsigned IdxW = $clog2(TableEntries);

  logic [IdxW-1:0] raddr;
  logic [23:0]     rdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [23:0]     wdata;

  pct_ctrl #(
    .TableEntries(TableEntries),
    .ColorLimit  (ColorLimit)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .action_i       (action_i),
    .pixel_i        (pixel_i),
    .busy_o         (busy),
    .done_o         (done_o),
    .palette_index_o(palette_index_o),
    .status_o       (status_o),
    .color_count_o  (color_count_o),
    .bit_depth_o    (bit_depth_o),
    .over_limit_o   (over_limit_o),
    .mem_raddr_o    (raddr),
    .mem_rdata_i    (rdata),
    .mem_we_o       (we),
    .mem_waddr_o    (waddr),
    .mem_wdata_o    (wdata)
  );

  pct_store #(
    .Entries(TableEntries),
    .Width  (24)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for palette_color_table: directed and random pixel beats; every result
// is compared field by field with a built-in model of the color palette.
// Depends on pct_pkg and the palette_color_table RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ActLearn = 1'b0;
  localparam logic ActMap   = 1'b1;

  localparam int unsigned TableSize    = pct_pkg::DefTableEntries;
  localparam int unsigned ColorCap     = pct_pkg::DefColorLimit;
  localparam int unsigned RandomBeats  = 1740;
  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    logic        action;
    logic [23:0] pixel;
    int unsigned gap;
    bit          drain;
  } pixel_beat_t;

  typedef struct {
    logic [7:0]       index;
    pct_pkg::status_e status;
    logic [8:0]       count;
    logic [3:0]       depth;
    logic             over;
  } palette_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        action = ActLearn;
  logic [23:0] pixel = '0;
  logic        busy;
  logic        done;
  logic [7:0]  palette_index;
  logic [1:0]  status;
  logic [8:0]  color_count;
  logic [3:0]  bit_depth;
  logic        over_limit;

  logic [23:0]     palette_colors [TableSize];
  int unsigned     palette_fill = 0;
  pixel_beat_t     pixel_queue [$];
  palette_result_t result_queue [$];
  logic [23:0]     learned_colors [$];
  int unsigned     issued_beats = 0;
  int unsigned     taken_beats = 0;
  int unsigned     gap_left = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     mismatches = 0;

  palette_color_table uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .action_i       (action),
    .pixel_i        (pixel),
    .done_o         (done),
    .palette_index_o(palette_index),
    .status_o       (status),
    .color_count_o  (color_count),
    .bit_depth_o    (bit_depth),
    .over_limit_o   (over_limit)
  );

  always #5 clk = ~clk;

  function automatic logic [3:0] palette_depth(input int unsigned n);
    int unsigned threshold;
    logic [3:0]  d;
    threshold = 1;
    d = '0;
    while (d < 4'd8 && n >= threshold) begin
      d++;
      threshold = threshold << 1;
    end
    return d;
  endfunction

  function automatic palette_result_t lookup_or_learn(input logic act, input logic [23:0] px);
    palette_result_t r;
    int              hit_at;
    hit_at = -1;
    for (int i = 0; i < palette_fill; i++) begin
      if (hit_at < 0 && palette_colors[i] == px) begin
        hit_at = i;
      end
    end
    r.index = '0;
    if (hit_at >= 0) begin
      r.index = hit_at[7:0];
      r.status = pct_pkg::StFound;
    end else if (act == ActMap) begin
      r.status = pct_pkg::StMissed;
    end else if (palette_fill < TableSize) begin
      palette_colors[palette_fill] = px;
      r.index = palette_fill[7:0];
      palette_fill++;
      r.status = pct_pkg::StInserted;
    end else begin
      r.status = pct_pkg::StFull;
    end
    r.count = palette_fill[8:0];
    r.depth = palette_depth(palette_fill);
    r.over = (palette_fill > ColorCap);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want_v);
    mismatches++;
  endtask

  task automatic add_beat(input logic act, input logic [23:0] px, input int unsigned gap,
                          input bit drain);
    pixel_beat_t b;
    b.action = act;
    b.pixel = px;
    b.gap = gap;
    b.drain = drain;
    pixel_queue.push_back(b);
    if (act == ActLearn) begin
      learned_colors.push_back(px);
    end
  endtask

  always @(negedge clk) begin : drive_beats
    pixel_beat_t nxt;
    if (rst_n && (!start || taken_beats == issued_beats)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pixel_queue.size() > 0 &&
                   (!pixel_queue[0].drain || result_queue.size() == 0)) begin
        nxt = pixel_queue.pop_front();
        start <= 1'b1;
        action <= nxt.action;
        pixel <= nxt.pixel;
        gap_left <= nxt.gap;
        issued_beats <= issued_beats + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    palette_result_t want;
    if (rst_n) begin
      if (done) begin
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result, index", palette_index, 0);
        end else begin
          want = result_queue.pop_front();
          if (palette_index !== want.index) begin
            report_mismatch("palette_index", palette_index, want.index);
          end
          if (status !== want.status) begin
            report_mismatch("status", status, want.status);
          end
          if (color_count !== want.count) begin
            report_mismatch("color_count", color_count, want.count);
          end
          if (bit_depth !== want.depth) begin
            report_mismatch("bit_depth", bit_depth, want.depth);
          end
          if (over_limit !== want.over) begin
            report_mismatch("over_limit", over_limit, want.over);
          end
        end
      end
      if (start && !busy) begin
        result_queue.push_back(lookup_or_learn(action, pixel));
        taken_beats <= taken_beats + 1;
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run
    logic        act;
    logic [23:0] px;
    int unsigned r;
    int unsigned gap;
    bit          calm;
    bit          drain;

    add_beat(ActMap,   24'h000000, 0, 1'b0);
    add_beat(ActLearn, 24'h000000, 0, 1'b0);
    add_beat(ActLearn, 24'hFFFFFF, 1, 1'b0);
    add_beat(ActLearn, 24'h000000, 0, 1'b0);
    add_beat(ActMap,   24'hFFFFFF, 0, 1'b0);
    add_beat(ActMap,   24'h800000, 2, 1'b0);
    add_beat(ActLearn, 24'h000001, 0, 1'b0);
    add_beat(ActLearn, 24'h800000, 0, 1'b0);
    add_beat(ActMap,   24'h000001, 0, 1'b0);
    add_beat(ActLearn, 24'h7FFFFF, 3, 1'b0);
    add_beat(ActMap,   24'h7FFFFF, 0, 1'b0);
    add_beat(ActLearn, 24'hFFFFFF, 0, 1'b0);

    calm = 1'b0;
    for (int b = 0; b < RandomBeats; b++) begin
      if (b % 50 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
        gap = 0;
      end else if (r < 90) begin
        gap = $urandom_range(1, 3);
      end else if (r < 97) begin
        gap = $urandom_range(4, 20);
      end else begin
        gap = $urandom_range(50, 300);
      end
      drain = (b == 0) || ($urandom_range(0, 99) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        act = ActLearn;
        px = 24'($urandom);
      end else if (r < 50) begin
        act = ActMap;
        px = 24'($urandom);
      end else if (r < 80) begin
        act = 1'($urandom_range(0, 1));
        px = learned_colors[$urandom_range(0, learned_colors.size() - 1)];
      end else if (r < 90) begin
        act = 1'($urandom_range(0, 1));
        px = learned_colors[$urandom_range(0, learned_colors.size() - 1)] ^
             (24'd1 << $urandom_range(0, 23));
      end else begin
        act = 1'($urandom_range(0, 1));
        px = 24'($urandom);
      end
      add_beat(act, px, gap, drain);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pixel_queue.size() > 0 || taken_beats != issued_beats ||
           result_queue.size() > 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
